// ----- hw/rtl/dedup_ring_waitlist_queue_macros.svh -----
// Assertion macros shared by the waitlist queue RTL.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef DEDUP_RING_WAITLIST_QUEUE_MACROS_SVH
`define DEDUP_RING_WAITLIST_QUEUE_MACROS_SVH

// Same-cycle implication.
`define DRWQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DRWQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/drwq_pkg.sv -----
// Shared types and constants for the waitlist queue.
// No dependencies; used by every RTL file of the block.
package drwq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_W            = 16;
    localparam int OCC_W           = 5;
    localparam int PAIR_W          = 2 * ID_W;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef enum logic [2:0] {
        ST_ENQUEUED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_DEQUEUED  = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

    typedef struct packed {
        logic            opcode;
        logic [ID_W-1:0] requester_id;
        logic [ID_W-1:0] target_id;
    } t_in_word;

    typedef struct packed {
        t_status          status;
        logic [ID_W-1:0]  front_requester;
        logic [ID_W-1:0]  front_target;
        logic [OCC_W-1:0] occupancy;
    } t_out_word;

endpackage

// ----- hw/rtl/dedup_ring_waitlist_queue.sv -----
// Waitlist queue with duplicate rejection: the sequencer and the output register.
// Depends on drwq_pkg, drwq_ctrl and drwq_ram.
//
// Usage:
//   Input channel  i_in_valid / i_in_word / o_in_stall carries one command word
//   (enqueue a requester/target pair, or dequeue the front pair). Output channel
//   o_out_valid / o_out_word / i_out_stall returns exactly one result word per
//   command: status, the removed pair on a dequeue (zero otherwise) and the
//   occupancy after the command.
//   One command is in flight at a time. The pairs live in a single synchronous
//   RAM; an enqueue reads the occupied entries one per cycle from the head and
//   stops at the first match. An empty-queue command finishes on acceptance, a
//   dequeue on a non-empty queue reads the head entry in S_DEQ, and an enqueue
//   scans until a match or the last held entry before writing or rejecting;
//   the next command is taken once the result has left for the output register.
//   The output register holds a result while i_out_stall is high; the next
//   command may already be accepted behind it, and its result waits until the
//   register frees up.
//   Reset sets head and count to zero and tail to the last slot; the queue comes
//   up empty and ready at once. RAM contents are never cleared.
module dedup_ring_waitlist_queue #(
    parameter int QUEUE_DEPTH = drwq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  drwq_pkg::t_in_word  i_in_word,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output drwq_pkg::t_out_word o_out_word,
    input  logic                i_out_stall
);

    logic                r_out_valid;
    drwq_pkg::t_out_word r_out_word;
    logic                res_valid;
    drwq_pkg::t_out_word res_word;
    logic                res_take;

    assign res_take = !r_out_valid || !i_out_stall;

    drwq_ctrl #(
        .DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_stall  (o_in_stall),
        .o_res_valid (res_valid),
        .o_res_word  (res_word),
        .i_res_take  (res_take)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take && res_valid) begin
            r_out_word <= res_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ----- hw/rtl/drwq_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on drwq_pkg for default sizes.
module drwq_ram #(
    parameter int WIDTH = drwq_pkg::PAIR_W,
    parameter int DEPTH = drwq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/drwq_ctrl.sv -----
// Queue sequencer: pointers, occupancy count, duplicate scan and dequeue read.
// Depends on drwq_pkg, drwq_ram and the shared assertion macros.
`include "dedup_ring_waitlist_queue_macros.svh"

module drwq_ctrl #(
    parameter int DEPTH = drwq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  drwq_pkg::t_in_word  i_in_word,
    output logic                o_in_stall,
    output logic                o_res_valid,
    output drwq_pkg::t_out_word o_res_word,
    input  logic                i_res_take
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_DEQ  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + PW'(1);
    endfunction

    t_state                       r_state, n_state;
    logic [PW-1:0]                r_head, n_head;
    logic [PW-1:0]                r_tail, n_tail;
    logic [CW-1:0]                r_count, n_count;
    logic [PW-1:0]                r_rd_ptr, n_rd_ptr;
    logic [PW-1:0]                r_idx, n_idx;
    logic [drwq_pkg::PAIR_W-1:0]  r_key, n_key;
    drwq_pkg::t_out_word          r_res, n_res;

    logic                         in_acc;
    logic [drwq_pkg::PAIR_W-1:0]  cur_key;
    logic                         ram_we;
    logic [PW-1:0]                ram_waddr;
    logic [PW-1:0]                ram_raddr;
    logic [drwq_pkg::PAIR_W-1:0]  ram_rdata;
    logic                         match;
    logic                         last_entry;
    logic                         enq_fin;
    logic                         dup;

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign cur_key    = (r_state == S_IDLE) ? {i_in_word.requester_id, i_in_word.target_id}
                                            : r_key;
    assign match      = (ram_rdata == r_key);
    assign last_entry = ((CW'(r_idx) + CW'(1)) == r_count);
    assign ram_waddr  = next_slot(r_tail);

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_rd_ptr = r_rd_ptr;
        n_idx    = r_idx;
        n_key    = r_key;
        n_res    = r_res;
        ram_we   = 1'b0;
        ram_raddr = r_rd_ptr;
        enq_fin  = 1'b0;
        dup      = 1'b0;
        case (r_state)
            S_IDLE: begin
                ram_raddr = r_head;
                if (in_acc) begin
                    n_key    = cur_key;
                    n_rd_ptr = next_slot(r_head);
                    n_idx    = '0;
                    if (i_in_word.opcode == drwq_pkg::OP_ENQ) begin
                        if (r_count == '0) begin
                            enq_fin = 1'b1;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else if (r_count == '0) begin
                        n_res.status          = drwq_pkg::ST_EMPTY;
                        n_res.front_requester = '0;
                        n_res.front_target    = '0;
                        n_res.occupancy       = drwq_pkg::OCC_W'(r_count);
                        n_state               = S_DONE;
                    end else begin
                        n_state = S_DEQ;
                    end
                end
            end
            S_SCAN: begin
                n_rd_ptr = next_slot(r_rd_ptr);
                n_idx    = r_idx + PW'(1);
                if (match) begin
                    enq_fin = 1'b1;
                    dup     = 1'b1;
                end else if (last_entry) begin
                    enq_fin = 1'b1;
                end
            end
            S_DEQ: begin
                n_head                = next_slot(r_head);
                n_count               = r_count - CW'(1);
                n_res.status          = drwq_pkg::ST_DEQUEUED;
                n_res.front_requester = ram_rdata[drwq_pkg::PAIR_W-1:drwq_pkg::ID_W];
                n_res.front_target    = ram_rdata[drwq_pkg::ID_W-1:0];
                n_res.occupancy       = drwq_pkg::OCC_W'(r_count - CW'(1));
                n_state               = S_DONE;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (enq_fin) begin
            n_state               = S_DONE;
            n_res.front_requester = '0;
            n_res.front_target    = '0;
            n_res.occupancy       = drwq_pkg::OCC_W'(r_count);
            if (dup) begin
                n_res.status = drwq_pkg::ST_DUPLICATE;
            end else if (r_count == FULL_CNT) begin
                n_res.status = drwq_pkg::ST_FULL;
            end else begin
                ram_we          = 1'b1;
                n_tail          = next_slot(r_tail);
                n_count         = r_count + CW'(1);
                n_res.status    = drwq_pkg::ST_ENQUEUED;
                n_res.occupancy = drwq_pkg::OCC_W'(r_count + CW'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= LAST_SLOT;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ptr <= n_rd_ptr;
        r_idx    <= n_idx;
        r_key    <= n_key;
        r_res    <= n_res;
    end

    drwq_ram #(
        .WIDTH (drwq_pkg::PAIR_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (cur_key),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res_word  = r_res;

    `DRWQ_ASSERT_NEXT(a_accept_leaves_idle, in_acc, r_state != S_IDLE, "accept did not start work")
    `DRWQ_ASSERT_NOW(a_count_bound, 1'b1, r_count <= FULL_CNT, "occupancy beyond depth")
    `DRWQ_ASSERT_NOW(a_deq_nonempty, r_state == S_DEQ, r_count != '0, "dequeue read on empty queue")
    `DRWQ_ASSERT_NEXT(a_write_grows, ram_we, r_count == $past(r_count) + CW'(1), "write without count step")

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Testbench for dedup_ring_waitlist_queue: directed and random enqueue/dequeue words,
// random input idling and output stalls, each result checked against a local model.
// Depends on drwq_pkg and the block's RTL.
module tb;
    import drwq_pkg::*;

    localparam int DEPTH         = QUEUE_DEPTH_DEF;
    localparam int RANDOM_ITEMS  = 1800;
    localparam int HOLD_CYCLES   = 150;
    localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
    localparam int POOL_SIZE     = 20;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } t_stall_mode;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_word  in_word   = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_word out_word;
    logic      out_stall = 1'b0;

    logic [ID_W-1:0] held_req [DEPTH];
    logic [ID_W-1:0] held_tgt [DEPTH];
    int              held_head;
    int              held_tail;
    int              held_count;

    logic [ID_W-1:0] pool_req [POOL_SIZE];
    logic [ID_W-1:0] pool_tgt [POOL_SIZE];

    t_out_word awaited_results[$];
    int        errors     = 0;
    int        burst_left = 0;
    bit        no_gaps    = 1'b0;
    bit        hold_req   = 1'b0;

    dedup_ring_waitlist_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_word   (in_word),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_word  (out_word),
        .i_out_stall (out_stall)
    );

    always #10 clk = ~clk;

    function automatic t_out_word predict_waitlist(input t_in_word w);
        t_out_word r;
        bit        dup;
        int        slot;
        r    = '0;
        dup  = 1'b0;
        slot = held_head;
        if (w.opcode == OP_ENQ) begin
            for (int i = 0; i < held_count; i++) begin
                if (held_req[slot] == w.requester_id && held_tgt[slot] == w.target_id) begin
                    dup = 1'b1;
                end
                slot = (slot + 1) % DEPTH;
            end
            if (dup) begin
                r.status = ST_DUPLICATE;
            end else if (held_count >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                held_tail           = (held_tail + 1) % DEPTH;
                held_req[held_tail] = w.requester_id;
                held_tgt[held_tail] = w.target_id;
                held_count++;
                r.status = ST_ENQUEUED;
            end
        end else if (held_count == 0) begin
            r.status = ST_EMPTY;
        end else begin
            r.front_requester = held_req[held_head];
            r.front_target    = held_tgt[held_head];
            held_head         = (held_head + 1) % DEPTH;
            held_count--;
            r.status = ST_DEQUEUED;
        end
        r.occupancy = OCC_W'(held_count);
        return r;
    endfunction

    function automatic t_in_word random_word(input int enq_pct);
        t_in_word w;
        int       pick;
        int       slot;
        int       b;
        w.opcode       = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
        w.requester_id = ID_W'($urandom);
        w.target_id    = ID_W'($urandom);
        pick           = $urandom_range(0, 99);
        if (w.opcode == OP_ENQ) begin
            if (pick < 35) begin
                slot           = $urandom_range(0, POOL_SIZE - 1);
                w.requester_id = pool_req[slot];
                w.target_id    = pool_tgt[slot];
            end else if (pick < 70 && held_count > 0) begin
                slot           = (held_head + $urandom_range(0, held_count - 1)) % DEPTH;
                w.requester_id = held_req[slot];
                w.target_id    = held_tgt[slot];
                if (pick >= 60) begin
                    b = $urandom_range(0, ID_W - 1);
                    if ($urandom_range(0, 1) == 0) begin
                        w.requester_id[b] = ~w.requester_id[b];
                    end else begin
                        w.target_id[b] = ~w.target_id[b];
                    end
                end
            end
        end
        return w;
    endfunction

    task automatic send_word(input logic op, input logic [ID_W-1:0] req,
                             input logic [ID_W-1:0] tgt);
        t_in_word w;
        int       gap;
        w.opcode       = op;
        w.requester_id = req;
        w.target_id    = tgt;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (no_gaps) begin
                gap = 0;
            end else if ($urandom_range(0, 3) == 0) begin
                gap = $urandom_range(4, 24);
            end else begin
                gap = $urandom_range(0, 3);
            end
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
        awaited_results.push_back(predict_waitlist(w));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic test_empty_dequeue();
        send_word(OP_DEQ, 16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_field_extremes();
        send_word(OP_ENQ, 16'h0000, 16'h0000);
        send_word(OP_ENQ, 16'hFFFF, 16'hFFFF);
        send_word(OP_ENQ, 16'h0000, 16'hFFFF);
        send_word(OP_ENQ, 16'hFFFF, 16'h0000);
        send_word(OP_ENQ, 16'hFFFF, 16'hFFFF);
        send_word(OP_ENQ, 16'hFFFF, 16'hFFFE);
        send_word(OP_ENQ, 16'hFFFE, 16'hFFFF);
    endtask

    task automatic test_fill_and_reject();
        for (int i = 0; held_count < DEPTH; i++) begin
            send_word(OP_ENQ, ID_W'(16'h1000 + i), ID_W'(16'h2000 + i));
        end
        send_word(OP_ENQ, 16'hABCD, 16'h1234);
        send_word(OP_ENQ, 16'h0000, 16'hFFFF);
    endtask

    task automatic test_wraparound();
        repeat (3) send_word(OP_DEQ, 16'h0000, 16'h0000);
        for (int i = 0; i < 3; i++) begin
            send_word(OP_ENQ, ID_W'(16'h3000 + i), ID_W'(16'h4000 + i));
        end
    endtask

    task automatic test_random_traffic(input int count);
        t_in_word w;
        int       phase_left;
        int       enq_pct;
        phase_left = 0;
        enq_pct    = 50;
        repeat (count) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(10, 60);
                case ($urandom_range(0, 2))
                    0: enq_pct = 85;
                    1: enq_pct = 50;
                    default: enq_pct = 15;
                endcase
                no_gaps = ($urandom_range(0, 4) == 0);
            end
            phase_left--;
            w = random_word(enq_pct);
            send_word(w.opcode, w.requester_id, w.target_id);
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_output_backpressure();
        t_in_word w;
        hold_req = 1'b1;
        no_gaps  = 1'b1;
        repeat (12) begin
            w = random_word(60);
            send_word(w.opcode, w.requester_id, w.target_id);
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_sender_pause();
        wait_drained();
        test_empty_dequeue();
    endtask

    initial begin : out_stall_gen
        t_stall_mode mode;
        int          mode_left;
        int          hold_left;
        mode      = STALL_NONE;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_stall_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 160);
                end
                mode_left--;
                case (mode)
                    STALL_NONE:  out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                    default:     out_stall <= ~out_stall;
                endcase
            end
        end
    end

    always @(posedge clk) begin : result_check
        t_out_word want;
        if (rst_n && out_valid && !out_stall) begin
            if (awaited_results.size() == 0) begin
                $error("unexpected result word %h", out_word);
                errors++;
            end else begin
                want = awaited_results.pop_front();
                if (out_word.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, out_word.status);
                    errors++;
                end
                if (out_word.front_requester !== want.front_requester) begin
                    $error("front_requester: expected %h, got %h",
                           want.front_requester, out_word.front_requester);
                    errors++;
                end
                if (out_word.front_target !== want.front_target) begin
                    $error("front_target: expected %h, got %h",
                           want.front_target, out_word.front_target);
                    errors++;
                end
                if (out_word.occupancy !== want.occupancy) begin
                    $error("occupancy: expected %0d, got %0d",
                           want.occupancy, out_word.occupancy);
                    errors++;
                end
            end
        end
    end

    initial begin : main_seq
        held_head  = 0;
        held_tail  = DEPTH - 1;
        held_count = 0;
        for (int k = 0; k < POOL_SIZE; k++) begin
            pool_req[k] = ID_W'($urandom);
            pool_tgt[k] = ID_W'($urandom);
            if (k % 2 == 1) begin
                pool_req[k] = pool_req[k - 1];
            end
        end
        pool_req[0] = '0;
        pool_tgt[0] = '0;
        pool_req[1] = '1;
        pool_tgt[1] = '1;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_empty_dequeue();
        test_field_extremes();
        test_fill_and_reject();
        test_wraparound();
        test_random_traffic(RANDOM_ITEMS / 2);
        test_output_backpressure();
        test_sender_pause();
        test_random_traffic(RANDOM_ITEMS / 2);

        wait_drained();
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/drwq_pkg.sv
hw/rtl/drwq_ram.sv
hw/rtl/drwq_ctrl.sv
hw/rtl/dedup_ring_waitlist_queue.sv
tb/tb.sv
